// ----- hw/rtl/leb_pkg.sv -----
`timescale 1ns / 1ps

package leb_pkg;

	localparam int WORD_BITS  = 64;
	localparam int GROUP_BITS = 7;
	localparam int LEN_W      = 4;

	localparam logic [6:0] GROUP_MASK = 7'h7f;
	localparam logic [7:0] MORE_BIT   = 8'h80;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TRUNC    = 2'd1;
	localparam logic [1:0] ST_OVERLONG = 2'd2;

	localparam logic [1:0] REG_DIRECTION = 2'd0;
	localparam logic [1:0] REG_SIGNED    = 2'd1;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [63:0] value_in;
		logic [3:0]  min_bytes;
		logic [7:0]  data_byte;
		logic        stream_end;
	} in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [63:0] value_out;
		logic [3:0]  length;
		logic [1:0]  status;
		logic        last;
	} out_t;

	typedef struct packed {
		logic enc_load;
		logic enc_step;
		logic dec_step;
		logic dec_clear;
		logic signed_mode;
	} cmd_t;

	typedef struct packed {
		logic enc_last;
		logic dec_emit;
	} stat_t;

endpackage

// ----- hw/rtl/leb_ctrl.sv -----
`timescale 1ns / 1ps

module leb_ctrl import leb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd,
	input  stat_t      stat
);

	typedef enum logic {
		S_IDLE,
		S_ENCODE
	} state_t;

	state_t state_q;
	logic   direction_q;
	logic   signed_q;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && ((direction_q == DIR_ENCODE) || slot_free);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.enc_load    = accept && (direction_q == DIR_ENCODE);
		cmd.dec_step    = accept && (direction_q == DIR_DECODE);
		cmd.enc_step    = (state_q == S_ENCODE) && slot_free;
		cmd.dec_clear   = cfg_we && ((cfg_index == REG_DIRECTION) || (cfg_index == REG_SIGNED));
		cmd.signed_mode = signed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			direction_q <= DIR_ENCODE;
			signed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_DIRECTION)
				direction_q <= cfg_data;
			if (cfg_we && cfg_index == REG_SIGNED)
				signed_q <= cfg_data;

			if (cmd.enc_step || (cmd.dec_step && stat.dec_emit))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (cmd.enc_load)
						state_q <= S_ENCODE;
				end
				S_ENCODE: begin
					if (cmd.enc_step && stat.enc_last)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/leb_dp.sv -----
`timescale 1ns / 1ps

module leb_dp import leb_pkg::*; #(
	parameter int VALUE_BITS = 64,
	parameter int MAX_BYTES  = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output stat_t stat,
	input  in_t   in_data,
	output out_t  out_data
);

	localparam logic [63:0]      VMASK   = {WORD_BITS{1'b1}} >> (WORD_BITS - VALUE_BITS);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);
	localparam logic [6:0]       VB7     = 7'(VALUE_BITS);

	logic [63:0]      v_q;
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] min_q;
	logic [63:0]      acc_q;
	logic [6:0]       bitpos_q;
	logic [LEN_W-1:0] cnt_q;
	out_t             out_q;

	function automatic logic [63:0] sext(input logic [63:0] x);
		logic [63:0] r;
		r = x & VMASK;
		if (x[VALUE_BITS-1])
			r = r | ~VMASK;
		return r;
	endfunction

	// encode step
	logic [6:0]       code;
	logic [63:0]      v_next;
	logic             more;
	logic [LEN_W:0]   n_inc;
	logic             enc_cut;
	out_t             enc_res;

	always_comb begin
		code  = v_q[6:0];
		n_inc = {1'b0, n_q} + 1'b1;
		if (cmd.signed_mode) begin
			v_next = {{GROUP_BITS{v_q[63]}}, v_q[63:GROUP_BITS]};
			more   = ((v_next != '0) || code[6]) && ((v_next != '1) || !code[6]);
		end else begin
			v_next = {{GROUP_BITS{1'b0}}, v_q[63:GROUP_BITS]};
			more   = (n_inc < {1'b0, min_q}) || (v_next != '0);
		end
		enc_cut = more && (n_inc >= {1'b0, MAX_LEN});
		enc_res.value_out = '0;
		if (more && !enc_cut) begin
			enc_res.out_byte = {1'b0, code} | MORE_BIT;
			enc_res.length   = '0;
			enc_res.status   = ST_OK;
			enc_res.last     = 1'b0;
		end else begin
			enc_res.out_byte = {1'b0, code};
			enc_res.length   = n_inc[LEN_W-1:0];
			enc_res.status   = enc_cut ? ST_OVERLONG : ST_OK;
			enc_res.last     = 1'b1;
		end
	end

	// decode step
	logic [7:0]       b;
	logic [63:0]      acc_new;
	logic [6:0]       bp_new;
	logic [LEN_W:0]   cnt_inc;
	logic [63:0]      dec_val;
	out_t             dec_res;
	logic             dec_emit;

	always_comb begin
		b       = in_data.data_byte;
		cnt_inc = {1'b0, cnt_q} + 1'b1;
		bp_new  = bitpos_q + 7'(GROUP_BITS);
		acc_new = acc_q;
		if (bitpos_q < VB7)
			acc_new = acc_q | ({57'b0, b[6:0] & GROUP_MASK} << bitpos_q[5:0]);
		acc_new = acc_new & VMASK;
		dec_val = acc_new;
		if (cmd.signed_mode) begin
			if (bp_new < VB7) begin
				if (b[6])
					dec_val = acc_new | ({WORD_BITS{1'b1}} << bp_new[5:0]);
			end else begin
				dec_val = sext(acc_new);
			end
		end
		dec_res.out_byte = '0;
		dec_res.last     = 1'b1;
		if (in_data.stream_end) begin
			dec_emit          = (cnt_q != '0);
			dec_res.value_out = '0;
			dec_res.length    = cnt_q;
			dec_res.status    = ST_TRUNC;
		end else if (b[7]) begin
			dec_emit          = (cnt_inc >= {1'b0, MAX_LEN});
			dec_res.value_out = '0;
			dec_res.length    = MAX_LEN;
			dec_res.status    = ST_OVERLONG;
		end else begin
			dec_emit          = 1'b1;
			dec_res.value_out = dec_val;
			dec_res.length    = cnt_inc[LEN_W-1:0];
			dec_res.status    = ST_OK;
		end
	end

	assign stat.enc_last = enc_res.last;
	assign stat.dec_emit = dec_emit;
	assign out_data      = out_q;

	always_ff @(posedge clk) begin
		if (cmd.enc_load) begin
			v_q   <= cmd.signed_mode ? sext(in_data.value_in) : (in_data.value_in & VMASK);
			n_q   <= '0;
			min_q <= (in_data.min_bytes > MAX_LEN) ? MAX_LEN : in_data.min_bytes;
		end else if (cmd.enc_step) begin
			v_q <= v_next;
			n_q <= n_inc[LEN_W-1:0];
		end
		if (cmd.enc_step)
			out_q <= enc_res;
		else if (cmd.dec_step && dec_emit)
			out_q <= dec_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			bitpos_q <= '0;
			cnt_q    <= '0;
		end else if (cmd.dec_clear || (cmd.dec_step && dec_emit)) begin
			acc_q    <= '0;
			bitpos_q <= '0;
			cnt_q    <= '0;
		end else if (cmd.dec_step && !in_data.stream_end) begin
			acc_q    <= acc_new;
			bitpos_q <= bp_new;
			cnt_q    <= cnt_inc[LEN_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/leb128_codec.sv -----
`timescale 1ns / 1ps
// LEB128 codec, 64-bit values.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 direction: 0 encode, 1 decode; 1 signed mode). Any write of a known
// register clears the decode state. Write only while the block is idle.
// Input (in_valid/in_ready, in_data): in encode mode one transaction is one
// value; in decode mode one transaction is one byte or a stream_end mark.
// Output (out_valid/out_ready, out_data): one transaction per encoded byte,
// or one per decoded value, truncated stream or overlong encoding.
// Encode: the value is loaded on acceptance; the sequencer then emits one
// byte per cycle into the output register while it is free. A new value
// is accepted once the last byte has been issued into the output register.
// Decode: one byte per cycle; a result is registered at the edge that
// accepts its final byte and shows the cycle after.
// A stalled receiver holds the output register; the sequencer and the byte
// input wait until it frees.
// Reset clears configuration to encode/unsigned, the decode state and the
// output valid.
module leb128_codec import leb_pkg::*; #(
	parameter int VALUE_BITS = 64,
	parameter int MAX_BYTES  = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data
);

	cmd_t  cmd;
	stat_t stat;

	leb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	leb_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_BYTES  (MAX_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.out_data (out_data)
	);

	a_last_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.length != '0)))
		else $error("length and last disagree");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> (out_data.value_out == '0))
		else $error("error result carries a value");

	a_more_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> out_data.out_byte[7])
		else $error("non-final byte lacks continuation bit");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.length <= LEN_W'(MAX_BYTES)))
		else $error("length beyond maximum");

endmodule
